/* hdl/rrfp_pkg.sv */
// Shared constants and types for the radar range frame parser.
`default_nettype none
package rrfp_pkg;

  localparam int unsigned DEFAULT_PAYLOAD_BYTES = 8;

  localparam logic [7:0]  PREAMBLE_BYTE     = 8'hAA;
  localparam logic [7:0]  POSTAMBLE_BYTE    = 8'h55;
  localparam logic [15:0] DEFAULT_TARGET_ID = 16'h070C;

  // Status from the frame FSM to the top level, valid in the cycle of a step.
  typedef struct packed {
    logic        at_end;     // next byte is the second postamble byte
    logic        res_valid;  // this step completes a matching frame
    logic [15:0] distance;
  } rrfp_fsm_stat_t;

endpackage
`default_nettype wire

/* hdl/rrfp_in_reg.sv */
// Input register stage for the received byte stream.
`default_nettype none
module rrfp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  input  wire logic       take,       // downstream consumes the held byte
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule
`default_nettype wire

/* hdl/rrfp_frame_fsm.sv */
// Frame deframing state machine, checksum and distance capture.
`default_nettype none
module rrfp_frame_fsm
  import rrfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = DEFAULT_PAYLOAD_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  output rrfp_fsm_stat_t   stat
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [CNT_W-1:0] IDX_DIST_HI = CNT_W'(2);
  localparam logic [CNT_W-1:0] IDX_DIST_LO = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(PAYLOAD_BYTES);

  typedef enum logic [2:0] {
    ST_PRE1,
    ST_PRE2,
    ST_ID_LO,
    ST_ID_HI,
    ST_PAYLOAD,
    ST_CHECK,
    ST_POST1,
    ST_POST2
  } state_t;

  state_t           state_r, state_nxt;
  logic [15:0]      target_r;
  logic [15:0]      id_r, id_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]       dist_hi_r, dist_lo_r;
  logic             match;

  assign cnt_inc = cnt_r + CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    match     = 1'b0;
    case (state_r)
      ST_PRE1: begin
        if (rx_byte == PREAMBLE_BYTE) state_nxt = ST_PRE2;
      end
      ST_PRE2: begin
        state_nxt = (rx_byte == PREAMBLE_BYTE) ? ST_ID_LO : ST_PRE1;
      end
      ST_ID_LO: begin
        id_nxt    = {8'h00, rx_byte};
        state_nxt = ST_ID_HI;
      end
      ST_ID_HI: begin
        id_nxt    = {rx_byte, id_r[7:0]};
        sum_nxt   = 8'h00;
        cnt_nxt   = '0;
        state_nxt = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        sum_nxt = sum_r + rx_byte;
        cnt_nxt = cnt_inc;
        if (cnt_inc == CNT_LAST) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (rx_byte == sum_r) ? ST_POST1 : ST_PRE1;
      end
      ST_POST1: begin
        state_nxt = (rx_byte == POSTAMBLE_BYTE) ? ST_POST2 : ST_PRE1;
      end
      ST_POST2: begin
        match     = (rx_byte == POSTAMBLE_BYTE) && (id_r == target_r);
        state_nxt = ST_PRE1;
      end
      default: begin
        state_nxt = ST_PRE1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_PRE1;
      id_r     <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      target_r <= DEFAULT_TARGET_ID;
    end else begin
      if (cfg_wr_en) target_r <= cfg_wr_data;
      if (step) begin
        state_r <= state_nxt;
        id_r    <= id_nxt;
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // Only payload bytes 2 and 3 are ever read, so only they are kept.
  always_ff @(posedge clk) begin
    if (step && state_r == ST_PAYLOAD) begin
      if (cnt_r == IDX_DIST_HI) dist_hi_r <= rx_byte;
      if (cnt_r == IDX_DIST_LO) dist_lo_r <= rx_byte;
    end
  end

  assign stat.at_end    = (state_r == ST_POST2);
  assign stat.res_valid = step && match;
  assign stat.distance  = {dist_hi_r, dist_lo_r};

endmodule
`default_nettype wire

/* hdl/rrfp_out_reg.sv */
// Result register feeding the output stream.
`default_nettype none
module rrfp_out_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire logic [15:0] load_data,
  output logic             free,      // register may take a new result
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata  // [15:0] target_range
);

  logic        valid_r, valid_nxt;
  logic [15:0] data_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

/* hdl/radar_range_frame_parser_unit.sv */
// Top level of the radar range frame parser.
`default_nettype none
// Takes one serial byte per request and deframes packets of the form
// AA AA, id low, id high, PAYLOAD_BYTES payload bytes, an 8-bit sum of the
// payload, 55 55. Any byte out of place drops back to preamble hunting.
// A good frame whose id equals the target id register (reset 0x070C) gives
// one result: payload bytes 2 and 3 as a big-endian distance in cm. Bytes
// pass through an input register and are parsed from it, so one byte is
// accepted per clock; the only stall is a final postamble byte that
// must wait while the previous result still sits unread in the output
// register. The parsed last byte loads the result into that register.
module radar_range_frame_parser_unit
  import rrfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = DEFAULT_PAYLOAD_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,  // [15:0] target_message_id
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata     // [15:0] target_range
);

  logic           byte_valid;
  logic [7:0]     byte_data;
  logic           step;
  logic           out_free;
  rrfp_fsm_stat_t fsm_stat;

  // A byte that may finish a frame waits until the result register is free.
  assign step = byte_valid && (!fsm_stat.at_end || out_free);

  rrfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  rrfp_frame_fsm #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_frame_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (byte_data),
    .stat        (fsm_stat)
  );

  rrfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fsm_stat.res_valid),
    .load_data  (fsm_stat.distance),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // A result is only produced into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    fsm_stat.res_valid |-> out_free)
    else $error("result produced while output register occupied");

  // A held byte that is not consumed stays held.
  a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && !step) |=> (byte_valid && $stable(byte_data)))
    else $error("pending input byte lost");

  // Only a byte at the frame end can be stalled.
  a_stall_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && !step) |-> (fsm_stat.at_end && out_tvalid && !out_tready))
    else $error("unexpected parser stall");
`endif

endmodule
`default_nettype wire
